// ===== rtl/bss_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bss_pkg
// Shared widths, constants and register codes of the bilinear sub-pixel
// shift block.
// ---------------------------------------------------------------------------
package bss_pkg;

	// Field widths of the ports.
	localparam int PIXEL_FIELD_W = 16;
	localparam int INDEX_FIELD_W = 12;
	localparam int SIZE_REG_W    = 13;
	localparam int FRAC_W        = 17;
	localparam int CFG_ADDR_W    = 2;
	localparam int CFG_DATA_W    = 17;

	// Frame sizes after clamping stay below 8192; they are held in 17 bits.
	localparam int SIZE_W = 17;

	// Weight factors (1-a), a, (1-b), b scaled by 65536 and their products.
	localparam int WT_W  = 19;
	localparam int K_W   = 2 * WT_W;
	localparam logic signed [WT_W-1:0] WT_ONE = 19'sd65536;

	// Rounding: the kernel sum is scaled by 2^32.
	localparam int FRAC_SHIFT = 32;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FRAME_ROWS   = 2'd0,
		REG_FRAME_COLS   = 2'd1,
		REG_COL_FRACTION = 2'd2,
		REG_ROW_FRACTION = 2'd3
	} cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/bilinear_subpixel_shift.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bilinear_subpixel_shift
// Raster-order 2x2 bilinear interpolation with a configurable sub-pixel
// column and row shift; the last row and column are replicated.
// ---------------------------------------------------------------------------
// Results pass stage 1, operand selection, products, pair sums, total and
// the output register. Throughput: one item per cycle unless the output
// stalls; an item with several results holds the single issue slot of the
// multiplier pipeline until all have issued (only at frame edges).
// Reset clears all control state and counters; the line memory is not
// cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module bilinear_subpixel_shift #(
	parameter int MAX_COLS   = 4096,
	parameter int MAX_ROWS   = 4096,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [bss_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire logic [bss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// Input pixel channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [bss_pkg::PIXEL_FIELD_W-1:0]   pixel_value,
	// Result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [bss_pkg::PIXEL_FIELD_W-1:0]        result_value,
	output logic [bss_pkg::INDEX_FIELD_W-1:0]        out_row,
	output logic [bss_pkg::INDEX_FIELD_W-1:0]        out_col,
	output logic                                     run_last
);

	localparam int PIX_W  = (PIXEL_BITS < bss_pkg::PIXEL_FIELD_W) ?
		PIXEL_BITS : bss_pkg::PIXEL_FIELD_W;
	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IW     = bss_pkg::INDEX_FIELD_W;
	localparam int K_W    = bss_pkg::K_W;
	localparam int PROD_W = K_W + PIX_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int TW     = SUM_W - bss_pkg::FRAC_SHIFT;
	localparam int SZ_W   = bss_pkg::SIZE_W;
	localparam logic signed [SUM_W-1:0] HALF =
		SUM_W'(1) <<< (bss_pkg::FRAC_SHIFT - 1);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [bss_pkg::SIZE_REG_W-1:0] frame_rows_q, frame_cols_q;
	logic [bss_pkg::FRAC_W-1:0]     col_fraction_q, row_fraction_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q   <= bss_pkg::SIZE_REG_W'(1);
			frame_cols_q   <= bss_pkg::SIZE_REG_W'(1);
			col_fraction_q <= '0;
			row_fraction_q <= '0;
		end else if (cfg_we) begin
			unique case (bss_pkg::cfg_reg_t'(cfg_addr))
				bss_pkg::REG_FRAME_ROWS:   frame_rows_q <= cfg_wdata[bss_pkg::SIZE_REG_W-1:0];
				bss_pkg::REG_FRAME_COLS:   frame_cols_q <= cfg_wdata[bss_pkg::SIZE_REG_W-1:0];
				bss_pkg::REG_COL_FRACTION: col_fraction_q <= cfg_wdata[bss_pkg::FRAC_W-1:0];
				bss_pkg::REG_ROW_FRACTION: row_fraction_q <= cfg_wdata[bss_pkg::FRAC_W-1:0];
			endcase
		end
	end

	// Effective last row and column indexes: zero acts as one, large sizes clamp.
	logic [SZ_W-1:0] rows_eff, cols_eff, rows_last, cols_last;

	always_comb begin
		if (frame_rows_q == '0) begin
			rows_eff = SZ_W'(1);
		end else if (SZ_W'(frame_rows_q) > SZ_W'(MAX_ROWS)) begin
			rows_eff = SZ_W'(MAX_ROWS);
		end else begin
			rows_eff = SZ_W'(frame_rows_q);
		end
		if (frame_cols_q == '0) begin
			cols_eff = SZ_W'(1);
		end else if (SZ_W'(frame_cols_q) > SZ_W'(MAX_COLS)) begin
			cols_eff = SZ_W'(MAX_COLS);
		end else begin
			cols_eff = SZ_W'(frame_cols_q);
		end
		rows_last = rows_eff - SZ_W'(1);
		cols_last = cols_eff - SZ_W'(1);
	end

	// Kernel weights, recomputed every cycle from the fraction registers.
	logic signed [bss_pkg::WT_W-1:0] frac_a, frac_b, om_a, om_b;
	logic signed [K_W-1:0]           k0_q, k1_q, k2_q, k3_q;

	always_comb begin
		frac_a = bss_pkg::WT_W'($signed(col_fraction_q));
		frac_b = bss_pkg::WT_W'($signed(row_fraction_q));
		om_a   = bss_pkg::WT_ONE - frac_a;
		om_b   = bss_pkg::WT_ONE - frac_b;
	end

	always_ff @(posedge clk) begin
		k0_q <= om_a * om_b;
		k1_q <= frac_a * om_b;
		k2_q <= frac_b * om_a;
		k3_q <= frac_a * frac_b;
	end

	// ---------------------------------------------------------------
	// Input side: counters, line memory and the issue stage
	// ---------------------------------------------------------------
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [PIX_W-1:0] left_q, ul_q, up_rd_q;
	logic             have_prev_q;
	logic [PIX_W-1:0] line_mem [MAX_COLS];

	logic [PIX_W-1:0] pix;
	logic             accept, last_col, last_row;
	logic [3:0]       mask_in;

	// Stage 1: the item waiting to issue its results.
	logic             v_s1;
	logic [PIX_W-1:0] p_s1, left_s1;
	logic [RW-1:0]    row_s1;
	logic [CW-1:0]    col_s1;
	logic [3:0]       mask_s1;

	logic             en2, en3, en4, en5, en_out;
	logic             issue, s1_done;
	logic [3:0]       sel, mask_rest;

	assign pix      = pixel_value[PIX_W-1:0];
	assign accept   = in_valid && in_ready;
	assign last_col = SZ_W'(col_q) >= cols_last;
	assign last_row = SZ_W'(row_q) >= rows_last;

	always_comb begin
		mask_in[0] = (row_q != '0) && (col_q != '0);
		mask_in[1] = (row_q != '0) && last_col;
		mask_in[2] = last_row && (col_q != '0);
		mask_in[3] = last_row && last_col;
	end

	// Read-first memory: the read returns the pixel one row above.
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_q         <= line_mem[col_q];
			line_mem[col_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			left_q      <= '0;
			ul_q        <= '0;
			have_prev_q <= 1'b0;
			v_s1        <= 1'b0;
			mask_s1     <= '0;
		end else begin
			if (accept) begin
				left_q      <= pix;
				have_prev_q <= 1'b1;
				// The previous item's upper pixel becomes the upper-left one.
				if (have_prev_q) begin
					ul_q <= up_rd_q;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : RW'(row_q + RW'(1));
				end else begin
					col_q <= CW'(col_q + CW'(1));
				end
				v_s1    <= 1'b1;
				mask_s1 <= mask_in;
			end else if (s1_done) begin
				v_s1    <= 1'b0;
				mask_s1 <= '0;
			end else if (issue) begin
				mask_s1 <= mask_rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1    <= pix;
			left_s1 <= left_q;
			row_s1  <= row_q;
			col_s1  <= col_q;
		end
	end

	// Lowest pending result goes first, which keeps raster order.
	always_comb begin
		sel = mask_s1 & (~mask_s1 + 4'd1);
		mask_rest = mask_s1 & ~sel;
	end

	assign issue    = v_s1 && (mask_s1 != '0) && en2;
	assign s1_done  = v_s1 && ((mask_s1 == '0) || (issue && (mask_rest == '0)));
	assign in_ready = !v_s1 || s1_done;

	// ---------------------------------------------------------------
	// Stage 2: operand selection
	// ---------------------------------------------------------------
	logic             v_s2, last_s2;
	logic [PIX_W-1:0] op0_s2, op1_s2, op2_s2, op3_s2;
	logic [IW-1:0]    row_s2, col_s2;

	logic [PIX_W-1:0] op0, op1, op2, op3;
	logic [RW-1:0]    row_sel;
	logic [CW-1:0]    col_sel;

	always_comb begin
		priority if (sel[0]) begin
			op0 = ul_q;    op1 = up_rd_q; op2 = left_s1; op3 = p_s1;
			row_sel = RW'(row_s1 - RW'(1));
			col_sel = CW'(col_s1 - CW'(1));
		end else if (sel[1]) begin
			op0 = up_rd_q; op1 = up_rd_q; op2 = p_s1;    op3 = p_s1;
			row_sel = RW'(row_s1 - RW'(1));
			col_sel = col_s1;
		end else if (sel[2]) begin
			op0 = left_s1; op1 = p_s1;    op2 = left_s1; op3 = p_s1;
			row_sel = row_s1;
			col_sel = CW'(col_s1 - CW'(1));
		end else begin
			op0 = p_s1;    op1 = p_s1;    op2 = p_s1;    op3 = p_s1;
			row_sel = row_s1;
			col_sel = col_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op0_s2  <= op0;
			op1_s2  <= op1;
			op2_s2  <= op2;
			op3_s2  <= op3;
			row_s2  <= IW'(row_sel);
			col_s2  <= IW'(col_sel);
			last_s2 <= (mask_rest == '0);
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: weight products; stage 4: pair sums; stage 5: total
	// ---------------------------------------------------------------
	logic                     v_s3, last_s3, v_s4, last_s4, v_s5, last_s5;
	logic signed [PROD_W-1:0] prod0_s3, prod1_s3, prod2_s3, prod3_s3;
	logic signed [SUM_W-1:0]  psum0_s4, psum1_s4, sum_s5;
	logic [IW-1:0]            row_s3, col_s3, row_s4, col_s4, row_s5, col_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			prod0_s3 <= k0_q * $signed({1'b0, op0_s2});
			prod1_s3 <= k1_q * $signed({1'b0, op1_s2});
			prod2_s3 <= k2_q * $signed({1'b0, op2_s2});
			prod3_s3 <= k3_q * $signed({1'b0, op3_s2});
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			last_s3  <= last_s2;
		end
		if (en4 && v_s3) begin
			psum0_s4 <= SUM_W'(prod0_s3) + SUM_W'(prod1_s3);
			psum1_s4 <= SUM_W'(prod2_s3) + SUM_W'(prod3_s3);
			row_s4   <= row_s3;
			col_s4   <= col_s3;
			last_s4  <= last_s3;
		end
		if (en5 && v_s4) begin
			sum_s5  <= psum0_s4 + psum1_s4;
			row_s5  <= row_s4;
			col_s5  <= col_s4;
			last_s5 <= last_s4;
		end
	end

	// ---------------------------------------------------------------
	// Output register: round half up and saturate
	// ---------------------------------------------------------------
	logic                    out_valid_q, run_last_q;
	logic [PIX_W-1:0]        res_q, res_next;
	logic [IW-1:0]           out_row_q, out_col_q;
	logic signed [SUM_W-1:0] rnd;
	logic [TW-1:0]           res_wide;

	always_comb begin
		rnd      = sum_s5 + HALF;
		res_wide = rnd[SUM_W-1:bss_pkg::FRAC_SHIFT];
		if (sum_s5 < 0) begin
			res_next = '0;
		end else if (res_wide[TW-1:PIX_W] != '0) begin
			res_next = '1;
		end else begin
			res_next = res_wide[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s5) begin
			res_q      <= res_next;
			out_row_q  <= row_s5;
			out_col_q  <= col_s5;
			run_last_q <= last_s5;
		end
	end

	// Each stage moves when it is empty or the stage after it moves.
	assign en_out = !out_valid_q || out_ready;
	assign en5    = !v_s5 || en_out;
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;

	assign out_valid    = out_valid_q;
	assign result_value = bss_pkg::PIXEL_FIELD_W'(res_q);
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign run_last     = run_last_q;

endmodule
`default_nettype wire

// ===== bench/bilinear_subpixel_shift_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_subpixel_shift_test
// Streams frames of pixels into the bilinear shift block and checks every
// interpolated pixel, with its row, column and last flag, against a
// predictor that keeps its own line store and frame counters.
// ---------------------------------------------------------------------------
module bilinear_subpixel_shift_test;

	localparam int       SIZE_LIMIT  = 4096;
	localparam longint   UNIT_WEIGHT = 65536;
	localparam longint   PIXEL_MAX   = 65535;
	localparam longint   HALF_LSB    = 64'sd2147483648;
	localparam int       QUIET_LIMIT = 3000;
	localparam int       DRAIN_WAIT  = 10;

	typedef struct packed {
		logic [bss_pkg::PIXEL_FIELD_W-1:0] value;
		logic [bss_pkg::INDEX_FIELD_W-1:0] row;
		logic [bss_pkg::INDEX_FIELD_W-1:0] col;
		logic                              last;
	} pixel_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	bss_pkg::cfg_reg_t                  cfg_addr;
	logic [bss_pkg::CFG_DATA_W-1:0]     cfg_wdata;
	logic                               in_valid;
	logic                               in_ready;
	logic [bss_pkg::PIXEL_FIELD_W-1:0]  pixel_value;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [bss_pkg::PIXEL_FIELD_W-1:0]  result_value;
	logic [bss_pkg::INDEX_FIELD_W-1:0]  out_row;
	logic [bss_pkg::INDEX_FIELD_W-1:0]  out_col;
	logic                               run_last;

	// Shadow copy of the configuration and of the block's frame state.
	logic [bss_pkg::SIZE_REG_W-1:0]     rows_reg;
	logic [bss_pkg::SIZE_REG_W-1:0]     cols_reg;
	logic signed [bss_pkg::FRAC_W-1:0]  col_frac_reg;
	logic signed [bss_pkg::FRAC_W-1:0]  row_frac_reg;
	logic [bss_pkg::PIXEL_FIELD_W-1:0]  row_above [SIZE_LIMIT];
	logic [bss_pkg::PIXEL_FIELD_W-1:0]  left_px;
	logic [bss_pkg::PIXEL_FIELD_W-1:0]  upper_left_px;
	int                                 next_row;
	int                                 next_col;

	pixel_result_t                      due_pixels[$];
	pixel_result_t                      oldest;
	int                                 send_idle_pct;
	int                                 recv_idle_pct;
	int                                 pixels_sent;
	int                                 fail_count = 0;
	int                                 quiet_cycles;

	bilinear_subpixel_shift uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_value  (pixel_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int effective_size(input logic [bss_pkg::SIZE_REG_W-1:0] v);
		if (v == 0)
			return 1;
		return (v > SIZE_LIMIT) ? SIZE_LIMIT : int'(v);
	endfunction

	function automatic logic [bss_pkg::PIXEL_FIELD_W-1:0] bilinear_blend(input longint p00,
			input longint p01, input longint p10, input longint p11);
		longint a, b, k0, k1, k2, k3, s, q;
		a = col_frac_reg;
		b = row_frac_reg;
		k0 = (UNIT_WEIGHT - a) * (UNIT_WEIGHT - b);
		k1 = a * (UNIT_WEIGHT - b);
		k2 = b * (UNIT_WEIGHT - a);
		k3 = a * b;
		s = k0 * p00 + k1 * p01 + k2 * p10 + k3 * p11;
		if (s < 0)
			return '0;
		q = (s + HALF_LSB) >>> 32;
		if (q > PIXEL_MAX)
			q = PIXEL_MAX;
		return q[bss_pkg::PIXEL_FIELD_W-1:0];
	endfunction

	task automatic add_due(input logic [bss_pkg::PIXEL_FIELD_W-1:0] value, input int row,
			input int col);
		due_pixels.push_back('{value, row[bss_pkg::INDEX_FIELD_W-1:0],
			col[bss_pkg::INDEX_FIELD_W-1:0], 1'b0});
	endtask

	// Works out the pixels that become due when this item arrives.
	task automatic interpolate_pixel(input logic [bss_pkg::PIXEL_FIELD_W-1:0] px);
		int rows, cols, r, c, ci, n;
		bit last_c, last_r;
		logic [bss_pkg::PIXEL_FIELD_W-1:0] up, ul, lf;
		rows = effective_size(rows_reg);
		cols = effective_size(cols_reg);
		r = next_row;
		c = next_col;
		last_c = (c >= cols - 1);
		last_r = (r >= rows - 1);
		ci = (c < SIZE_LIMIT) ? c : SIZE_LIMIT - 1;
		up = row_above[ci];
		ul = upper_left_px;
		lf = left_px;
		n = 0;
		if (r >= 1 && c >= 1) begin
			add_due(bilinear_blend(ul, up, lf, px), r - 1, c - 1);
			n++;
		end
		if (r >= 1 && last_c) begin
			add_due(bilinear_blend(up, up, px, px), r - 1, c);
			n++;
		end
		if (last_r && c >= 1) begin
			add_due(bilinear_blend(lf, px, lf, px), r, c - 1);
			n++;
		end
		if (last_r && last_c) begin
			add_due(bilinear_blend(px, px, px, px), r, c);
			n++;
		end
		if (n > 0)
			due_pixels[due_pixels.size() - 1].last = 1'b1;
		upper_left_px = up;
		left_px = px;
		row_above[ci] = px;
		if (last_c) begin
			next_col = 0;
			next_row = last_r ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
	endtask

	task automatic write_reg(input bss_pkg::cfg_reg_t idx,
			input logic [bss_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bss_pkg::REG_FRAME_ROWS:   rows_reg = val[bss_pkg::SIZE_REG_W-1:0];
			bss_pkg::REG_FRAME_COLS:   cols_reg = val[bss_pkg::SIZE_REG_W-1:0];
			bss_pkg::REG_COL_FRACTION: col_frac_reg = val;
			bss_pkg::REG_ROW_FRACTION: row_frac_reg = val;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [bss_pkg::PIXEL_FIELD_W-1:0] px);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= px;
		do @(posedge clk); while (!in_ready);
		interpolate_pixel(px);
		pixels_sent++;
	endtask

	// Stops the input and waits until every due pixel has come out; items
	// that release nothing may still be in flight, hence the extra cycles.
	task automatic wait_drained;
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [bss_pkg::PIXEL_FIELD_W-1:0] random_pixel;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return bss_pkg::PIXEL_FIELD_W'($urandom);
		endcase
	endfunction

	function automatic logic [bss_pkg::FRAC_W-1:0] random_fraction;
		case ($urandom_range(8))
			0: return 17'h10000;
			1: return 17'h10001;
			2: return 17'h0FFFF;
			3: return '0;
			default: return bss_pkg::FRAC_W'($urandom_range(0, 131071));
		endcase
	endfunction

	// Sends pixels until the frame counters wrap back to the first pixel.
	task automatic finish_frame;
		do send_pixel(random_pixel());
		while (next_row != 0 || next_col != 0);
	endtask

	task automatic test_reset_config;
		send_pixel('0);
		send_pixel('1);
		wait_drained();
	endtask

	task automatic test_fraction_extremes;
		write_reg(bss_pkg::REG_FRAME_ROWS, 17'd2);
		write_reg(bss_pkg::REG_FRAME_COLS, 17'd2);
		write_reg(bss_pkg::REG_COL_FRACTION, 17'h10000);
		write_reg(bss_pkg::REG_ROW_FRACTION, 17'h0FFFF);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		wait_drained();
		write_reg(bss_pkg::REG_COL_FRACTION, 17'h0FFFF);
		write_reg(bss_pkg::REG_ROW_FRACTION, 17'h10001);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		wait_drained();
	endtask

	task automatic test_size_clamping;
		// A zero row count acts as one row; an oversize column count is clamped.
		write_reg(bss_pkg::REG_FRAME_ROWS, 17'd0);
		write_reg(bss_pkg::REG_FRAME_COLS, 17'd8191);
		write_reg(bss_pkg::REG_COL_FRACTION, 17'h08000);
		write_reg(bss_pkg::REG_ROW_FRACTION, 17'h18000);
		send_pixel(16'h1234);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		wait_drained();
		write_reg(bss_pkg::REG_FRAME_COLS, 17'd2);
		send_pixel(16'h8000);
		wait_drained();
		write_reg(bss_pkg::REG_FRAME_ROWS, 17'd4096);
		write_reg(bss_pkg::REG_FRAME_COLS, 17'd0);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'hA5A5);
		wait_drained();
		// The row counter is now past the new last row.
		write_reg(bss_pkg::REG_FRAME_ROWS, 17'd2);
		send_pixel(16'h5A5A);
		wait_drained();
	endtask

	task automatic test_mid_frame_change;
		write_reg(bss_pkg::REG_FRAME_ROWS, 17'd3);
		write_reg(bss_pkg::REG_FRAME_COLS, 17'd4);
		write_reg(bss_pkg::REG_COL_FRACTION, 17'd16384);
		write_reg(bss_pkg::REG_ROW_FRACTION, 17'h1B1E0);
		repeat (6) send_pixel(random_pixel());
		wait_drained();
		write_reg(bss_pkg::REG_FRAME_COLS, 17'd2);
		finish_frame();
		wait_drained();
	endtask

	// Whole frames of random size and content. Some frames are cut short,
	// reconfigured, and then completed; the column count never grows there,
	// so every line store entry read has been written first.
	task automatic test_random_frames(input int n_items);
		int stop_at, sel, cols, k;
		stop_at = pixels_sent + n_items;
		while (pixels_sent < stop_at) begin
			wait_drained();
			sel = $urandom_range(15);
			write_reg(bss_pkg::REG_FRAME_ROWS,
				(sel == 0) ? 17'd0 : 17'($urandom_range(1, 5)));
			sel = $urandom_range(15);
			if (sel == 0)
				cols = 0;
			else if (sel == 1)
				cols = $urandom_range(9, 40);
			else
				cols = $urandom_range(1, 8);
			write_reg(bss_pkg::REG_FRAME_COLS, 17'(cols));
			write_reg(bss_pkg::REG_COL_FRACTION, random_fraction());
			write_reg(bss_pkg::REG_ROW_FRACTION, random_fraction());
			k = effective_size(rows_reg) * effective_size(cols_reg);
			if ($urandom_range(4) == 0 && k > 1) begin
				repeat ($urandom_range(1, k - 1)) send_pixel(random_pixel());
				wait_drained();
				write_reg(bss_pkg::REG_FRAME_ROWS, 17'($urandom_range(1, 6)));
				write_reg(bss_pkg::REG_FRAME_COLS,
					17'($urandom_range(1, effective_size(cols_reg))));
				if ($urandom_range(1) == 0)
					write_reg(bss_pkg::REG_COL_FRACTION, random_fraction());
			end
			finish_frame();
		end
		wait_drained();
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_pixels.size() == 0) begin
				$error("unexpected result at row %0d col %0d", out_row, out_col);
				fail_count++;
			end else begin
				oldest = due_pixels.pop_front();
				if (result_value !== oldest.value) begin
					$error("result_value: expected %0d, actual %0d", oldest.value,
						result_value);
					fail_count++;
				end
				if (out_row !== oldest.row) begin
					$error("out_row: expected %0d, actual %0d", oldest.row, out_row);
					fail_count++;
				end
				if (out_col !== oldest.col) begin
					$error("out_col: expected %0d, actual %0d", oldest.col, out_col);
					fail_count++;
				end
				if (run_last !== oldest.last) begin
					$error("run_last: expected %0d, actual %0d", oldest.last, run_last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = bss_pkg::REG_FRAME_ROWS;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel_value = '0;
		rows_reg = 13'd1;
		cols_reg = 13'd1;
		col_frac_reg = '0;
		row_frac_reg = '0;
		left_px = '0;
		upper_left_px = '0;
		next_row = 0;
		next_col = 0;
		pixels_sent = 0;
		foreach (row_above[i])
			row_above[i] = '0;
		send_idle_pct = 24;
		recv_idle_pct = 87;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_config();
		test_fraction_extremes();
		test_size_clamping();
		test_mid_frame_change();
		test_random_frames(40);
		send_idle_pct = 87;
		recv_idle_pct = 24;
		test_random_frames(40);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(35);
		wait_drained();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
